FILE: rtl/core/crc8df_pkg.sv
// shared types, constants and the crc step for the crc8 packet deframer
// no dependencies; imported by crc8_packet_deframer_core

package crc8df_pkg;

    localparam int MAX_DATA = 32;
    localparam int ADDR_W   = $clog2(MAX_DATA);
    localparam int LEN_W    = 6;

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] SYNC_RST = 8'hAA;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_WORK,
        CTL_STREAM
    } ctl_state_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    // reflected crc8, one byte, lsb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] d;
        logic       mix;
        crc = crc_in;
        d   = data_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = crc[0] ^ d[0];
            crc = {1'b0, crc[7:1]};
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/crc8df_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the deframer payload bytes

module crc8df_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/crc8_packet_deframer_core.sv
// byte-serial frame parser: sync, cmd, len, payload, crc8 check, payload stream out
// depends on crc8df_pkg and crc8df_ram
//
// channel | direction | handshake         | payload
// --------+-----------+-------------------+-----------------------------------------
// in      | in        | in_valid/in_stall | rx_byte
// out     | out       | out_valid/out_stall | status, frame_cmd, frame_len, byte_index,
//         |           |                   | payload_byte, last
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (sync byte)
//
// each input byte is captured first, then updates the parser state and writes the payload
// ram. a good frame with n payload bytes then streams n results, one per cycle while
// out_stall is low, as the ram read for the next byte overlaps the current result.
// out_stall holds the output register and the stream; in_stall stays high until done.
// reset is asynchronous; the payload ram needs no clearing pass.

module crc8_packet_deframer_core
    import crc8df_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [7:0]        frame_cmd,
    output logic [LEN_W-1:0]  frame_len,
    output logic [ADDR_W-1:0] byte_index,
    output logic [7:0]        payload_byte,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    ctl_state_t        ctl_reg, ctl_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        sync_byte_reg;
    logic [7:0]        in_byte_reg;
    logic [7:0]        held_cmd_reg, held_cmd_next;
    logic [LEN_W-1:0]  held_len_reg, held_len_next;
    logic [LEN_W-1:0]  fill_index_reg, fill_index_next;
    logic [7:0]        crc_reg, crc_next;
    logic [ADDR_W-1:0] stream_idx_reg, stream_idx_next;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        frame_cmd_reg;
    logic [LEN_W-1:0]  frame_len_reg;
    logic [ADDR_W-1:0] byte_index_reg;
    logic [7:0]        payload_byte_reg;
    logic              last_reg;

    // parser response for the byte in in_byte_reg
    status_t           rsp_status;
    logic [7:0]        rsp_cmd;
    logic              rsp_stream;
    logic              wr_en;

    logic              out_free;
    logic              work_go;
    logic              stream_last;
    logic              out_load;
    logic [1:0]        load_status;
    logic [7:0]        load_cmd;
    logic [LEN_W-1:0]  load_len;
    logic [ADDR_W-1:0] load_index;
    logic [7:0]        load_byte;
    logic              load_last;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [LEN_W-1:0]  fill_inc;

    assign out_free    = !out_valid_reg || !out_stall;
    assign work_go     = (ctl_reg == CTL_WORK) && out_free;
    assign stream_last = (LEN_W'(stream_idx_reg) + LEN_W'(1)) == held_len_reg;
    assign fill_inc    = fill_index_reg + LEN_W'(1);

    crc8df_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_index_reg[ADDR_W-1:0]),
        .wr_data (in_byte_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // parser state update
    always_comb
    begin
        phase_next      = phase_reg;
        held_cmd_next   = held_cmd_reg;
        held_len_next   = held_len_reg;
        fill_index_next = fill_index_reg;
        crc_next        = crc_reg;
        rsp_status      = ST_BUSY;
        rsp_cmd         = 8'h00;
        rsp_stream      = 1'b0;
        wr_en           = 1'b0;
        unique case (phase_reg)
            PH_SYNC:
            begin
                if (in_byte_reg == sync_byte_reg)
                begin
                    phase_next = PH_CMD;
                    crc_next   = 8'h00;
                end
            end
            PH_CMD:
            begin
                held_cmd_next = in_byte_reg;
                crc_next      = crc8_update(8'h00, in_byte_reg);
                phase_next    = PH_LEN;
            end
            PH_LEN:
            begin
                fill_index_next = '0;
                if ({1'b0, in_byte_reg} > 9'(MAX_DATA))
                begin
                    phase_next    = PH_SYNC;
                    held_cmd_next = 8'h00;
                    held_len_next = '0;
                    crc_next      = 8'h00;
                    rsp_status    = ST_FAIL;
                end
                else
                begin
                    held_len_next = in_byte_reg[LEN_W-1:0];
                    crc_next      = crc8_update(crc_reg, in_byte_reg);
                    phase_next    = (in_byte_reg[LEN_W-1:0] == '0) ? PH_CHK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                wr_en           = work_go && (fill_index_reg < LEN_W'(MAX_DATA));
                crc_next        = crc8_update(crc_reg, in_byte_reg);
                fill_index_next = fill_inc;
                if (fill_inc >= held_len_reg)
                begin
                    phase_next = PH_CHK;
                end
            end
            PH_CHK:
            begin
                if (in_byte_reg != crc_reg)
                begin
                    phase_next      = PH_SYNC;
                    held_cmd_next   = 8'h00;
                    held_len_next   = '0;
                    fill_index_next = '0;
                    crc_next        = 8'h00;
                    rsp_status      = ST_FAIL;
                end
                else
                begin
                    phase_next      = PH_SYNC;
                    fill_index_next = '0;
                    rsp_status      = ST_DONE;
                    rsp_cmd         = held_cmd_reg;
                    rsp_stream      = (held_len_reg != '0);
                end
            end
            default:
            begin
                phase_next      = PH_SYNC;
                held_cmd_next   = 8'h00;
                held_len_next   = '0;
                fill_index_next = '0;
                crc_next        = 8'h00;
                rsp_status      = ST_FAIL;
            end
        endcase
    end

    // control next state
    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            CTL_IDLE:
            begin
                if (in_valid)
                begin
                    ctl_next = CTL_WORK;
                end
            end
            CTL_WORK:
            begin
                if (work_go)
                begin
                    ctl_next = rsp_stream ? CTL_STREAM : CTL_IDLE;
                end
            end
            CTL_STREAM:
            begin
                if (out_free && stream_last)
                begin
                    ctl_next = CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall        = 1'b1;
        out_load        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        stream_idx_next = stream_idx_reg;
        load_status     = ST_BUSY;
        load_cmd        = 8'h00;
        load_len        = '0;
        load_index      = '0;
        load_byte       = 8'h00;
        load_last       = 1'b1;
        unique case (ctl_reg)
            CTL_IDLE:
            begin
                in_stall = 1'b0;
            end
            CTL_WORK:
            begin
                stream_idx_next = '0;
                if (work_go)
                begin
                    if (rsp_stream)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        out_load    = 1'b1;
                        load_status = rsp_status;
                        load_cmd    = rsp_cmd;
                    end
                end
            end
            CTL_STREAM:
            begin
                load_status = ST_DONE;
                load_cmd    = held_cmd_reg;
                load_len    = held_len_reg;
                load_index  = stream_idx_reg;
                load_byte   = rd_data;
                load_last   = stream_last;
                if (out_free)
                begin
                    out_load        = 1'b1;
                    stream_idx_next = stream_idx_reg + ADDR_W'(1);
                    // fetch the next byte while this one goes out
                    rd_en   = !stream_last;
                    rd_addr = stream_idx_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg        <= CTL_IDLE;
            phase_reg      <= PH_SYNC;
            sync_byte_reg  <= SYNC_RST;
            held_cmd_reg   <= 8'h00;
            held_len_reg   <= '0;
            fill_index_reg <= '0;
            crc_reg        <= 8'h00;
            stream_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctl_reg        <= ctl_next;
            stream_idx_reg <= stream_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                sync_byte_reg <= cfg_data;
            end
            if (work_go)
            begin
                phase_reg      <= phase_next;
                held_cmd_reg   <= held_cmd_next;
                held_len_reg   <= held_len_next;
                fill_index_reg <= fill_index_next;
                crc_reg        <= crc_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // capture and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (out_load)
        begin
            status_reg       <= load_status;
            frame_cmd_reg    <= load_cmd;
            frame_len_reg    <= load_len;
            byte_index_reg   <= load_index;
            payload_byte_reg <= load_byte;
            last_reg         <= load_last;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_cmd    = frame_cmd_reg;
    assign frame_len    = frame_len_reg;
    assign byte_index   = byte_index_reg;
    assign payload_byte = payload_byte_reg;
    assign last         = last_reg;

endmodule

FILE: tb/crc8_packet_deframer_core_tb.sv
// self-checking testbench for crc8_packet_deframer_core: frame stimulus, own parser predictor
// depends on crc8df_pkg and the deframer rtl; no files, no arguments

module crc8_packet_deframer_core_tb;
    import crc8df_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [7:0]          cmd;
        logic [LEN_W-1:0]    len;
        logic [ADDR_W-1:0]   idx;
        logic [7:0]          data;
        logic                last;
    } frame_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [7:0]        frame_cmd;
    logic [LEN_W-1:0]  frame_len;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        payload_byte;
    logic              last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data = 8'h00;

    // predictor state
    phase_t            ph;
    logic [7:0]        sync_val;
    logic [7:0]        cur_cmd;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  fill_cnt;
    logic [7:0]        crc_acc;
    logic [7:0]        payload_mem [MAX_DATA];
    frame_result_t     pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_bytes = 0;
    int n_busy = 0;
    int n_done = 0;
    int n_fail = 0;
    int n_errors = 0;
    int n_sync_settings = 1;
    int n_pauses = 0;

    crc8_packet_deframer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .frame_cmd    (frame_cmd),
        .frame_len    (frame_len),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 300000);
        $display("crc8_packet_deframer_core regression: fail");
        $finish;
    end

    task automatic report_error(input string msg);
        n_errors++;
        $display("ERROR t=%0t: %s", $time, msg);
    endtask

    // crc8 maxim, reflected: fold the byte in first, then shift out eight bits
    function automatic logic [7:0] crc8_maxim(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] c;
        c = acc ^ d;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    task automatic push_result(input status_t s, input logic [7:0] cmd,
                               input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] idx,
                               input logic [7:0] data, input logic lst);
        frame_result_t r;
        r.status = s;
        r.cmd    = cmd;
        r.len    = len;
        r.idx    = idx;
        r.data   = data;
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    task automatic clear_frame();
        ph       = PH_SYNC;
        cur_cmd  = 8'h00;
        cur_len  = '0;
        fill_cnt = '0;
        crc_acc  = 8'h00;
    endtask

    // parser predictor: one accepted byte in, expected results queued
    task automatic deframe_byte(input logic [7:0] b);
        case (ph)
            PH_SYNC:
            begin
                if (b == sync_val)
                begin
                    ph      = PH_CMD;
                    crc_acc = 8'h00;
                end
                push_result(ST_BUSY, 8'h00, '0, '0, 8'h00, 1'b1);
            end
            PH_CMD:
            begin
                cur_cmd = b;
                crc_acc = crc8_maxim(8'h00, b);
                ph      = PH_LEN;
                push_result(ST_BUSY, 8'h00, '0, '0, 8'h00, 1'b1);
            end
            PH_LEN:
            begin
                fill_cnt = '0;
                if (b > MAX_DATA)
                begin
                    clear_frame();
                    push_result(ST_FAIL, 8'h00, '0, '0, 8'h00, 1'b1);
                end
                else
                begin
                    cur_len = b[LEN_W-1:0];
                    crc_acc = crc8_maxim(crc_acc, b);
                    ph      = (cur_len == 0) ? PH_CHK : PH_DATA;
                    push_result(ST_BUSY, 8'h00, '0, '0, 8'h00, 1'b1);
                end
            end
            PH_DATA:
            begin
                payload_mem[fill_cnt[ADDR_W-1:0]] = b;
                crc_acc  = crc8_maxim(crc_acc, b);
                fill_cnt = fill_cnt + 1'b1;
                if (fill_cnt >= cur_len)
                begin
                    ph = PH_CHK;
                end
                push_result(ST_BUSY, 8'h00, '0, '0, 8'h00, 1'b1);
            end
            PH_CHK:
            begin
                if (b != crc_acc)
                begin
                    clear_frame();
                    push_result(ST_FAIL, 8'h00, '0, '0, 8'h00, 1'b1);
                end
                else
                begin
                    ph       = PH_SYNC;
                    fill_cnt = '0;
                    if (cur_len == 0)
                    begin
                        push_result(ST_DONE, cur_cmd, '0, '0, 8'h00, 1'b1);
                    end
                    else
                    begin
                        for (int k = 0; k < cur_len; k++)
                        begin
                            push_result(ST_DONE, cur_cmd, cur_len, k[ADDR_W-1:0],
                                        payload_mem[k], (k + 1 == cur_len));
                        end
                    end
                end
            end
            default:
            begin
                clear_frame();
                push_result(ST_FAIL, 8'h00, '0, '0, 8'h00, 1'b1);
            end
        endcase
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result with none expected: status %0d cmd %02h",
                                       status, frame_cmd));
            end
            else
            begin
                want = pending_results.pop_front();
                case (want.status)
                    ST_BUSY: n_busy++;
                    ST_DONE: n_done++;
                    default: n_fail++;
                endcase
                if (status !== want.status)
                    report_error($sformatf("status %0d, want %0d", status, want.status));
                if (frame_cmd !== want.cmd)
                    report_error($sformatf("frame_cmd %02h, want %02h", frame_cmd, want.cmd));
                if (frame_len !== want.len)
                    report_error($sformatf("frame_len %0d, want %0d", frame_len, want.len));
                if (byte_index !== want.idx)
                    report_error($sformatf("byte_index %0d, want %0d", byte_index, want.idx));
                if (payload_byte !== want.data)
                    report_error($sformatf("payload_byte %02h, want %02h",
                                           payload_byte, want.data));
                if (last !== want.last)
                    report_error($sformatf("last %0b, want %0b", last, want.last));
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        n_bytes++;
        deframe_byte(b);
    endtask

    // hold the input until every expected result is out
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    task automatic write_sync(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sync_val = v;
        n_sync_settings++;
    endtask

    // bytes that do not start a frame while hunting
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            while (ph == PH_SYNC && b == sync_val)
            begin
                b = 8'($urandom);
            end
            send_byte(b);
        end
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_b,
                              input bit bad_crc, input bit rand_fill,
                              input logic [7:0] fill);
        logic [7:0] chk;
        while (ph != PH_SYNC)
        begin
            send_byte(8'($urandom));
        end
        send_byte(sync_val);
        send_byte(cmd);
        send_byte(len_b);
        if (len_b <= MAX_DATA)
        begin
            for (int k = 0; k < len_b; k++)
            begin
                send_byte(rand_fill ? 8'($urandom) : fill);
            end
            chk = crc_acc;
            if (bad_crc)
            begin
                chk = chk ^ 8'($urandom_range(1, 255));
            end
            send_byte(chk);
        end
    endtask

    task automatic test_basic_frames();
        send_noise(1);
        send_frame(8'h00, 8'd0, 1'b0, 1'b0, 8'h00);
        send_frame(8'hFF, 8'd1, 1'b0, 1'b0, 8'hFF);
        send_frame(8'h5A, 8'd2, 1'b0, 1'b0, 8'h00);
        drain();
    endtask

    task automatic test_frame_errors();
        // length just past the store, then the largest length byte
        send_frame(8'h11, 8'd33, 1'b0, 1'b1, 8'h00);
        send_frame(8'h22, 8'd255, 1'b0, 1'b1, 8'h00);
        send_frame(8'h33, 8'd1, 1'b1, 1'b1, 8'h00);
        drain();
    endtask

    task automatic test_sync_register();
        write_sync(8'h00);
        send_noise(2);
        send_frame(8'h81, 8'd1, 1'b0, 1'b1, 8'h00);
        drain();
        write_sync(8'hFF);
        send_frame(8'h7E, 8'd0, 1'b0, 1'b1, 8'h00);
        drain();
    endtask

    task automatic test_random_traffic(input int idle_in, input int stall_out,
                                       input logic [7:0] sync_setting, input int n_items);
        int first;
        int pick;
        send_idle_pct  = idle_in;
        recv_stall_pct = stall_out;
        write_sync(sync_setting);
        first = n_bytes;
        send_frame(8'($urandom), 8'(MAX_DATA), 1'b0, 1'b1, 8'h00);
        while (n_bytes - first < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(8'($urandom), ($urandom_range(0, 9) == 0) ?
                           8'($urandom_range(0, MAX_DATA)) : 8'($urandom_range(0, 6)),
                           1'b0, 1'b1, 8'h00);
            else if (pick < 78)
                send_frame(8'($urandom), 8'($urandom_range(0, 6)), 1'b1, 1'b1, 8'h00);
            else if (pick < 84)
                send_frame(8'($urandom), 8'($urandom_range(MAX_DATA + 1, 255)),
                           1'b0, 1'b1, 8'h00);
            else
                send_noise($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0)
            begin
                drain();
                n_pauses++;
            end
        end
        drain();
    endtask

    initial
    begin
        sync_val = SYNC_RST;
        clear_frame();
        send_idle_pct  = 9;
        recv_stall_pct = 74;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_frames();
        test_frame_errors();
        test_sync_register();
        test_random_traffic(9, 74, 8'($urandom), 90);
        test_random_traffic(74, 9, 8'h00, 90);
        test_random_traffic(0, 0, SYNC_RST, 90);

        repeat (40) @(posedge clk);
        $display("covered %0d input bytes: %0d in-progress, %0d frame, %0d error results",
                 n_bytes, n_busy, n_done, n_fail);
        $display("sync settings used %0d, mid-stream pauses %0d", n_sync_settings, n_pauses);
        if (n_errors == 0 && pending_results.size() == 0)
        begin
            $display("crc8_packet_deframer_core regression: pass");
        end
        else
        begin
            $display("crc8_packet_deframer_core regression: fail");
        end
        $finish;
    end

endmodule
